[src/interval_overlap_matcher_defines.svh]
// Assertion macros for the interval overlap matcher.
// Expects a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef INTERVAL_OVERLAP_MATCHER_DEFINES_SVH
`define INTERVAL_OVERLAP_MATCHER_DEFINES_SVH

// Condition and consequence in the same cycle.
`define IOM_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Consequence in the cycle after the condition.
`define IOM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

[src/iom_pkg.sv]
// Shared widths and codes for the interval overlap matcher.
// No dependencies.
package iom_pkg;

    localparam int unsigned BOUND_W   = 32;
    localparam int unsigned IDX_W     = 31;
    localparam int unsigned SLOT_IN_W = 5;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

endpackage

[src/interval_overlap_matcher.sv]
// Interval overlap matcher: reference table, slot scan sequencer and output register.
// Depends on iom_pkg and interval_overlap_matcher_defines.svh.
//
// Channel   Direction  Handshake          Payload
// input     in         i_valid / o_ready  i_kind, i_slot, i_low_bound, i_high_bound
// result    out        o_valid / i_ready  o_ref_index, o_end_marker
// config    in         i_cfg_we           i_cfg_data (index_base)
//
// A load produces no result.
// A query makes one read of the reference memory and one overlap compare per slot, then
// issues the end marker; o_ready stays low until the end marker is issued.
// A stalled result register holds the scan on a hit until the pending result is taken.
// Reset clears the sequencer, the output valid and index_base; the table is not cleared.

`include "interval_overlap_matcher_defines.svh"

module interval_overlap_matcher
    import iom_pkg::*;
#(
    parameter int unsigned REF_SLOTS = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic                       i_kind,
    input  logic [SLOT_IN_W-1:0]       i_slot,
    input  logic signed [BOUND_W-1:0]  i_low_bound,
    input  logic signed [BOUND_W-1:0]  i_high_bound,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [IDX_W-1:0]           o_ref_index,
    output logic                       o_end_marker,
    input  logic                       i_cfg_we,
    input  logic [IDX_W-1:0]           i_cfg_data
);

    localparam int unsigned SLOT_W = (REF_SLOTS > 1) ? $clog2(REF_SLOTS) : 1;
    localparam int unsigned EXT_W  = 7;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(REF_SLOTS - 1);
    localparam logic [SLOT_W-1:0] ONE_SLOT  = SLOT_W'(1);
    localparam logic [EXT_W-1:0]  SLOT_LIM  = EXT_W'(REF_SLOTS);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_END
    } t_state;

    t_state                     r_state, n_state;
    logic [SLOT_W-1:0]          r_cnt, n_cnt;
    logic signed [BOUND_W-1:0]  r_q_lo, n_q_lo;
    logic signed [BOUND_W-1:0]  r_q_hi, n_q_hi;
    logic                       r_out_valid, n_out_valid;
    logic [IDX_W-1:0]           r_out_idx, n_out_idx;
    logic                       r_out_end, n_out_end;
    logic [IDX_W-1:0]           r_index_base;

    logic [2*BOUND_W-1:0]       r_ref_mem [REF_SLOTS];
    logic [2*BOUND_W-1:0]       r_rd_data;

    logic                       w_in_xfer;
    logic                       w_out_busy;
    logic                       w_hit;
    logic                       w_rd_en;
    logic [SLOT_W-1:0]          w_rd_addr;
    logic [EXT_W-1:0]           w_slot_ext;
    logic                       w_wr_en;
    logic signed [BOUND_W-1:0]  w_ref_lo;
    logic signed [BOUND_W-1:0]  w_ref_hi;

    assign o_ready      = (r_state == S_IDLE);
    assign o_valid      = r_out_valid;
    assign o_ref_index  = r_out_idx;
    assign o_end_marker = r_out_end;

    assign w_in_xfer  = i_valid && o_ready;
    assign w_out_busy = r_out_valid && !i_ready;
    assign w_slot_ext = {2'b00, i_slot};
    assign w_wr_en    = w_in_xfer && (i_kind == KIND_LOAD) && (w_slot_ext < SLOT_LIM);

    assign w_ref_lo = r_rd_data[BOUND_W-1:0];
    assign w_ref_hi = r_rd_data[2*BOUND_W-1:BOUND_W];
    assign w_hit    = !((r_q_hi < w_ref_lo) || (w_ref_hi < r_q_lo));

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_q_lo      = r_q_lo;
        n_q_hi      = r_q_hi;
        n_out_valid = w_out_busy;
        n_out_idx   = r_out_idx;
        n_out_end   = r_out_end;
        w_rd_en     = 1'b0;
        w_rd_addr   = '0;
        case (r_state)
            S_IDLE: begin
                if (w_in_xfer && (i_kind == KIND_QUERY)) begin
                    n_state = S_SCAN;
                    n_cnt   = '0;
                    n_q_lo  = i_low_bound;
                    n_q_hi  = i_high_bound;
                    w_rd_en = 1'b1;
                end
            end
            S_SCAN: begin
                if (!(w_hit && w_out_busy)) begin
                    if (w_hit) begin
                        n_out_valid = 1'b1;
                        n_out_idx   = IDX_W'(r_cnt) + r_index_base;
                        n_out_end   = 1'b0;
                    end
                    if (r_cnt == LAST_SLOT) begin
                        n_state = S_END;
                    end else begin
                        n_cnt     = r_cnt + ONE_SLOT;
                        w_rd_en   = 1'b1;
                        w_rd_addr = r_cnt + ONE_SLOT;
                    end
                end
            end
            S_END: begin
                if (!w_out_busy) begin
                    n_out_valid = 1'b1;
                    n_out_idx   = '0;
                    n_out_end   = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_ref_mem[w_slot_ext[SLOT_W-1:0]] <= {i_high_bound, i_low_bound};
        end
        if (w_rd_en) begin
            r_rd_data <= r_ref_mem[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_cnt        <= '0;
            r_out_valid  <= 1'b0;
            r_index_base <= '0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_index_base <= i_cfg_data;
            end
        end
        r_q_lo    <= n_q_lo;
        r_q_hi    <= n_q_hi;
        r_out_idx <= n_out_idx;
        r_out_end <= n_out_end;
    end

    `IOM_ASSERT_SAME(a_marker_zero, o_valid && o_end_marker, o_ref_index == '0,
        "End marker carries a nonzero index.")
    `IOM_ASSERT_SAME(a_cnt_range, r_state == S_SCAN, r_cnt <= LAST_SLOT,
        "Scan counter left the slot range.")
    `IOM_ASSERT_NEXT(a_query_start, w_in_xfer && (i_kind == KIND_QUERY),
        (r_state == S_SCAN) && (r_cnt == '0), "Query transfer did not start a scan.")
    `IOM_ASSERT_NEXT(a_end_done, (r_state == S_END) && !w_out_busy,
        (r_state == S_IDLE) && o_valid && o_end_marker, "End marker was not issued.")
    `IOM_ASSERT_NEXT(a_stall_hold, (r_state == S_SCAN) && w_hit && w_out_busy,
        $stable(r_cnt) && (r_state == S_SCAN), "Scan advanced past a stalled hit.")

endmodule

[tb/sv/testbench.sv]
// Self-checking testbench for interval_overlap_matcher: loads the reference table,
// sends query transfers and checks every result against an in-bench overlap predictor.
// Depends on iom_pkg and the interval_overlap_matcher RTL.
module testbench;
    import iom_pkg::*;

    localparam int unsigned REF_SLOTS = 32;
    localparam int unsigned SCAN_TAIL = REF_SLOTS + 6;
    localparam logic [IDX_W-1:0] INDEX_BASE_MAX = 31'd2147483583;
    localparam logic signed [BOUND_W-1:0] BOUND_MIN = 32'sh8000_0000;
    localparam logic signed [BOUND_W-1:0] BOUND_MAX = 32'sh7FFF_FFFF;

    typedef struct packed {
        logic [IDX_W-1:0] ref_index;
        logic             end_marker;
    } t_match;

    logic                      i_clk;
    logic                      i_rst_n = 1'b0;
    logic                      i_valid = 1'b0;
    logic                      o_ready;
    logic                      i_kind = KIND_LOAD;
    logic [SLOT_IN_W-1:0]      i_slot = '0;
    logic signed [BOUND_W-1:0] i_low_bound = '0;
    logic signed [BOUND_W-1:0] i_high_bound = '0;
    logic                      o_valid;
    logic                      i_ready = 1'b0;
    logic [IDX_W-1:0]          o_ref_index;
    logic                      o_end_marker;
    logic                      i_cfg_we = 1'b0;
    logic [IDX_W-1:0]          i_cfg_data = '0;

    logic signed [BOUND_W-1:0] ref_low_copy [REF_SLOTS];
    logic signed [BOUND_W-1:0] ref_high_copy [REF_SLOTS];
    logic [IDX_W-1:0]          index_base_copy = '0;
    t_match                    pending_matches [$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_request = 0;
    int hold_left = 0;
    int failures = 0;

    interval_overlap_matcher #(
        .REF_SLOTS(REF_SLOTS)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_kind      (i_kind),
        .i_slot      (i_slot),
        .i_low_bound (i_low_bound),
        .i_high_bound(i_high_bound),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_ref_index (o_ref_index),
        .o_end_marker(o_end_marker),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic void predict_overlaps(input logic signed [BOUND_W-1:0] q_lo,
                                             input logic signed [BOUND_W-1:0] q_hi);
        t_match           m;
        logic [IDX_W-1:0] slot_idx;
        for (int s = 0; s < REF_SLOTS; s++) begin
            if (!(q_hi < ref_low_copy[s] || ref_high_copy[s] < q_lo)) begin
                slot_idx = s[IDX_W-1:0];
                m.ref_index = slot_idx + index_base_copy;
                m.end_marker = 1'b0;
                pending_matches.push_back(m);
            end
        end
        m.ref_index = '0;
        m.end_marker = 1'b1;
        pending_matches.push_back(m);
    endfunction

    function automatic void pick_interval(output logic signed [BOUND_W-1:0] lo,
                                          output logic signed [BOUND_W-1:0] hi);
        int mode;
        int base;
        mode = $urandom_range(99);
        base = $urandom_range(400) - 200;
        if (mode < 60) begin
            lo = base;
            hi = base + $urandom_range(80);
        end else if (mode < 75) begin
            lo = $urandom;
            hi = $urandom;
        end else if (mode < 85) begin
            lo = base + $urandom_range(1, 40);
            hi = base;
        end else if (mode < 92) begin
            lo = BOUND_MIN + $urandom_range(3);
            hi = base;
        end else begin
            lo = base;
            hi = BOUND_MAX - $urandom_range(3);
        end
    endfunction

    task automatic send_item(input logic kind, input logic [SLOT_IN_W-1:0] slot,
                             input logic signed [BOUND_W-1:0] lo,
                             input logic signed [BOUND_W-1:0] hi);
        int gap;
        gap = 0;
        if ($urandom_range(99) < send_idle_pct) begin
            gap = ($urandom_range(3) == 0) ? $urandom_range(5, 40) : $urandom_range(1, 4);
        end
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_kind <= kind;
        i_slot <= slot;
        i_low_bound <= lo;
        i_high_bound <= hi;
        do @(posedge i_clk); while (o_ready !== 1'b1);
        if (kind == KIND_LOAD) begin
            ref_low_copy[slot] = lo;
            ref_high_copy[slot] = hi;
        end else begin
            predict_overlaps(lo, hi);
        end
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        while (pending_matches.size() != 0) @(posedge i_clk);
        repeat (SCAN_TAIL) @(posedge i_clk);
    endtask

    task automatic write_index_base(input logic [IDX_W-1:0] value);
        wait_idle();
        i_cfg_we <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        index_base_copy = value;
        i_cfg_we <= 1'b0;
    endtask

    task automatic test_table_load();
        logic signed [BOUND_W-1:0] lo;
        logic signed [BOUND_W-1:0] hi;
        for (int s = 0; s < REF_SLOTS; s++) begin
            case (s)
                0: begin
                    lo = BOUND_MIN;
                    hi = BOUND_MIN;
                end
                1: begin
                    lo = BOUND_MAX;
                    hi = BOUND_MAX;
                end
                2: begin
                    lo = BOUND_MIN;
                    hi = BOUND_MAX;
                end
                3: begin
                    lo = 100;
                    hi = -100;
                end
                4: begin
                    lo = 0;
                    hi = 0;
                end
                5: begin
                    lo = -1;
                    hi = -1;
                end
                default: pick_interval(lo, hi);
            endcase
            send_item(KIND_LOAD, s[SLOT_IN_W-1:0], lo, hi);
        end
    endtask

    task automatic test_directed_queries();
        send_item(KIND_QUERY, 5'd0, BOUND_MIN, BOUND_MAX);
        send_item(KIND_QUERY, 5'd31, BOUND_MIN, BOUND_MIN);
        send_item(KIND_QUERY, 5'd7, BOUND_MAX, BOUND_MAX);
        send_item(KIND_QUERY, 5'd0, 0, 0);
        send_item(KIND_QUERY, 5'd0, -1, 0);
        send_item(KIND_QUERY, 5'd3, 50, -50);
        send_item(KIND_QUERY, 5'd0, BOUND_MAX, BOUND_MIN);
        send_item(KIND_QUERY, 5'd0, 1000000, 2000000);
    endtask

    task automatic test_index_base_extremes();
        write_index_base(INDEX_BASE_MAX);
        send_item(KIND_QUERY, 5'd0, BOUND_MIN, BOUND_MAX);
        send_item(KIND_QUERY, 5'd0, -1, 0);
        write_index_base('0);
        send_item(KIND_QUERY, 5'd0, BOUND_MIN, BOUND_MAX);
    endtask

    task automatic test_random_traffic(input int count);
        logic signed [BOUND_W-1:0] lo;
        logic signed [BOUND_W-1:0] hi;
        logic                      kind;
        for (int n = 0; n < count; n++) begin
            kind = ($urandom_range(99) < 35) ? KIND_LOAD : KIND_QUERY;
            pick_interval(lo, hi);
            send_item(kind, SLOT_IN_W'($urandom_range(REF_SLOTS - 1)), lo, hi);
        end
    endtask

    task automatic test_output_backpressure();
        hold_request = 400;
        for (int n = 0; n < 12; n++) begin
            send_item(KIND_QUERY, SLOT_IN_W'($urandom_range(REF_SLOTS - 1)), BOUND_MIN,
                      BOUND_MAX);
        end
        wait_idle();
    endtask

    always @(posedge i_clk) begin
        if (hold_request != 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_match exp_m;
        if (i_rst_n && o_valid === 1'b1 && i_ready) begin
            if (pending_matches.size() == 0) begin
                $error("unexpected result transfer: ref_index %0d end_marker %0b",
                       o_ref_index, o_end_marker);
                failures++;
            end else begin
                exp_m = pending_matches.pop_front();
                if (o_ref_index !== exp_m.ref_index) begin
                    $error("ref_index: expected %0d, actual %0d", exp_m.ref_index,
                           o_ref_index);
                    failures++;
                end
                if (o_end_marker !== exp_m.end_marker) begin
                    $error("end_marker: expected %0b, actual %0b", exp_m.end_marker,
                           o_end_marker);
                    failures++;
                end
            end
        end
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 33;
        recv_idle_pct = 80;
        test_table_load();
        test_directed_queries();
        test_index_base_extremes();
        test_random_traffic(130);

        write_index_base(IDX_W'($urandom_range(INDEX_BASE_MAX)));
        send_idle_pct = 80;
        recv_idle_pct = 33;
        test_random_traffic(130);

        write_index_base(IDX_W'($urandom_range(1000)));
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(130);
        test_output_backpressure();

        wait_idle();
        if (failures == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule

[interval_overlap_matcher.f]
+incdir+src
src/iom_pkg.sv
src/interval_overlap_matcher.sv
tb/sv/testbench.sv
